// File: rtl/rkt_pkg.sv
// shared types and constants of the reference counted key table
// entry layout, operation and status codes, count helpers
// no dependencies
package rkt_pkg;

  typedef enum logic [1:0] {
    FN_CREATE       = 2'd0,
    FN_LOOKUP_INODE = 2'd1,
    FN_LOOKUP_UUID  = 2'd2,
    FN_RELEASE      = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_BAD_SLOT  = 2'd3
  } status_t;

  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] INITIAL_COUNT = 32'd2;

  // one table row as held in the entry memory
  typedef struct packed {
    logic        valid;
    logic [63:0] inode;
    logic [63:0] uuid_hi;
    logic [63:0] uuid_lo;
    logic [63:0] handle;
    logic [31:0] count;
    logic [31:0] stamp;
  } entry_t;

  // controls from the sequencer to the match unit
  typedef struct packed {
    logic clear;
    logic eval;
    logic by_uuid;
  } match_ctl_t;

  function automatic logic [31:0] count_bump(input logic [31:0] c);
    return (c == COUNT_MAX) ? c : c + 32'd1;
  endfunction

endpackage

// File: rtl/refcounted_key_table_top.sv
// top level of the reference counted key table: sequencer, entry memory, result register
// uses rkt_match_unit for the row scan
// depends on rkt_pkg
//
//   channel   ports                          beat taken when
//   ------    -----------------------------  ----------------------------
//   input     start, busy, in_*              rising edge with start=1, busy=0
//   result    out_valid, out_*               rising edge ending the out_valid cycle
//
// create and both lookups scan every row once through the single memory read port, then finish:
// busy through the scan and the finishing state, result strobed in the cycle after.
// release reads one row and writes it back: busy during the release state, result strobed in the cycle after.
// after reset a clearing pass over every row zeroes the valid marks, busy meanwhile.
// the result is strobed for one cycle only; the receiver cannot stall it.
module refcounted_key_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_inode,
  input  logic [63:0] in_uuid_hi,
  input  logic [63:0] in_uuid_lo,
  input  logic [63:0] in_handle,
  input  logic [5:0]  in_slot,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_entry_slot,
  output logic [63:0] out_entry_inode,
  output logic [63:0] out_entry_uuid_hi,
  output logic [63:0] out_entry_uuid_lo,
  output logic [63:0] out_entry_handle,
  output logic        out_created_new,
  output logic        out_freed
);
  import rkt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FINISH = 5'b01000,
    S_REL    = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0]   next_stamp_r, next_stamp_nxt;

  func_t         q_func_r;
  logic [63:0]   q_inode_r;
  logic [63:0]   q_uuid_hi_r;
  logic [63:0]   q_uuid_lo_r;
  logic [63:0]   q_handle_r;
  logic [AW-1:0] q_slot_r;
  logic          q_slot_ok_r;

  entry_t        mem [TABLE_DEPTH];
  entry_t        rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  logic          accept;
  logic          slot_in_range;
  logic          idx_at_end;

  match_ctl_t    mctl;
  logic          m_found, m_free_found;
  entry_t        m_best;
  logic [AW-1:0] m_best_slot, m_free_slot;

  logic          res_fire;
  status_t       res_status;
  logic [AW-1:0] res_slot;
  entry_t        res_entry;
  logic          res_created, res_freed;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [5:0]    out_slot_r;
  logic [63:0]   out_inode_r, out_uuid_hi_r, out_uuid_lo_r, out_handle_r;
  logic          out_created_r, out_freed_r;

  assign busy          = (state_r != S_IDLE);
  assign accept        = start && !busy;
  assign slot_in_range = (32'(in_slot) < 32'(TABLE_DEPTH));
  assign idx_at_end    = (idx_r == CW'(TABLE_DEPTH));

  // entry memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  assign mctl.clear   = accept;
  assign mctl.eval    = (state_r == S_SCAN) && (idx_r != '0);
  assign mctl.by_uuid = (q_func_r == FN_LOOKUP_UUID);

  rkt_match_unit #(.TABLE_DEPTH(TABLE_DEPTH)) u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (mctl),
    .rd_entry    (rd_data_r),
    .rd_slot     (AW'(idx_r - CW'(1))),
    .key_inode   (q_inode_r),
    .key_uuid_hi (q_uuid_hi_r),
    .key_uuid_lo (q_uuid_lo_r),
    .next_stamp  (next_stamp_r),
    .found       (m_found),
    .best_entry  (m_best),
    .best_slot   (m_best_slot),
    .free_found  (m_free_found),
    .free_slot   (m_free_slot)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    next_stamp_nxt = next_stamp_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    res_fire       = 1'b0;
    res_status     = STS_OK;
    res_slot       = '0;
    res_entry      = '0;
    res_created    = 1'b0;
    res_freed      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        if (idx_r == CW'(TABLE_DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      S_IDLE: begin
        mem_raddr = AW'(in_slot);
        mem_re    = accept && slot_in_range;
        if (accept) begin
          idx_nxt   = '0;
          state_nxt = (func_t'(in_func) == FN_RELEASE) ? S_REL : S_SCAN;
        end
      end

      S_SCAN: begin
        // read row idx while the match unit judges row idx-1
        mem_raddr = AW'(idx_r);
        mem_re    = !idx_at_end;
        idx_nxt   = idx_r + CW'(1);
        if (idx_at_end) state_nxt = S_FINISH;
      end

      S_FINISH: begin
        res_fire  = 1'b1;
        state_nxt = S_IDLE;
        if (m_found) begin
          mem_we          = 1'b1;
          mem_waddr       = m_best_slot;
          mem_wdata       = m_best;
          mem_wdata.count = count_bump(m_best.count);
          res_slot        = m_best_slot;
          res_entry       = m_best;
        end else if ((q_func_r == FN_CREATE) && m_free_found) begin
          mem_we            = 1'b1;
          mem_waddr         = m_free_slot;
          mem_wdata.valid   = 1'b1;
          mem_wdata.inode   = q_inode_r;
          mem_wdata.uuid_hi = q_uuid_hi_r;
          mem_wdata.uuid_lo = q_uuid_lo_r;
          mem_wdata.handle  = q_handle_r;
          mem_wdata.count   = INITIAL_COUNT;
          mem_wdata.stamp   = next_stamp_r;
          next_stamp_nxt    = next_stamp_r + 32'd1;
          res_slot          = m_free_slot;
          res_entry         = mem_wdata;
          res_created       = 1'b1;
        end else if (q_func_r == FN_CREATE) begin
          res_status = STS_FULL;
        end else begin
          res_status = STS_NOT_FOUND;
        end
      end

      S_REL: begin
        res_fire  = 1'b1;
        state_nxt = S_IDLE;
        if (!q_slot_ok_r || !rd_data_r.valid) begin
          res_status = STS_BAD_SLOT;
        end else begin
          res_slot  = q_slot_r;
          res_entry = rd_data_r;
          mem_we    = 1'b1;
          mem_waddr = q_slot_r;
          mem_wdata = rd_data_r;
          if (rd_data_r.count <= 32'd1) begin
            mem_wdata.valid = 1'b0;
            mem_wdata.count = '0;
            res_freed       = 1'b1;
          end else begin
            mem_wdata.count = rd_data_r.count - 32'd1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      idx_r        <= '0;
      next_stamp_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      next_stamp_r <= next_stamp_nxt;
      out_valid_r  <= res_fire;
    end
  end

  // captured request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      q_func_r    <= func_t'(in_func);
      q_inode_r   <= in_inode;
      q_uuid_hi_r <= in_uuid_hi;
      q_uuid_lo_r <= in_uuid_lo;
      q_handle_r  <= in_handle;
      q_slot_r    <= AW'(in_slot);
      q_slot_ok_r <= slot_in_range;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_status_r  <= res_status;
      out_slot_r    <= 6'(res_slot);
      out_inode_r   <= res_entry.inode;
      out_uuid_hi_r <= res_entry.uuid_hi;
      out_uuid_lo_r <= res_entry.uuid_lo;
      out_handle_r  <= res_entry.handle;
      out_created_r <= res_created;
      out_freed_r   <= res_freed;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_slot    = out_slot_r;
  assign out_entry_inode   = out_inode_r;
  assign out_entry_uuid_hi = out_uuid_hi_r;
  assign out_entry_uuid_lo = out_uuid_lo_r;
  assign out_entry_handle  = out_handle_r;
  assign out_created_new   = out_created_r;
  assign out_freed         = out_freed_r;

endmodule

// File: rtl/rkt_match_unit.sv
// shared key compare unit of the reference counted key table
// walks the rows one per cycle, keeps the best key hit and the lowest free slot
// depends on rkt_pkg
module rkt_match_unit #(
  parameter int TABLE_DEPTH = 64,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rkt_pkg::match_ctl_t ctl,
  input  rkt_pkg::entry_t     rd_entry,
  input  logic [AW-1:0]       rd_slot,
  input  logic [63:0]         key_inode,
  input  logic [63:0]         key_uuid_hi,
  input  logic [63:0]         key_uuid_lo,
  input  logic [31:0]         next_stamp,
  output logic                found,
  output rkt_pkg::entry_t     best_entry,
  output logic [AW-1:0]       best_slot,
  output logic                free_found,
  output logic [AW-1:0]       free_slot
);
  import rkt_pkg::*;

  logic          found_r;
  logic          free_found_r;
  entry_t        best_entry_r;
  logic [AW-1:0] best_slot_r;
  logic [AW-1:0] free_slot_r;
  logic [31:0]   best_age_r;

  logic [127:0] cmp_a;
  logic [127:0] cmp_b;
  logic         key_hit;
  logic [31:0]  age;
  logic         take;
  logic         take_free;

  // one 128-bit comparator serves both key kinds
  assign cmp_a = ctl.by_uuid ? {key_uuid_hi, key_uuid_lo} : {64'd0, key_inode};
  assign cmp_b = ctl.by_uuid ? {rd_entry.uuid_hi, rd_entry.uuid_lo}
                             : {64'd0, rd_entry.inode};
  assign key_hit = rd_entry.valid && (cmp_a == cmp_b);

  // wrapping distance from the newest insert, smaller is newer
  assign age  = next_stamp - rd_entry.stamp;
  assign take = key_hit && (!found_r || (ctl.by_uuid && (age < best_age_r)));
  assign take_free = !rd_entry.valid && !free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctl.eval) begin
      if (take) found_r <= 1'b1;
      if (take_free) free_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval && take) begin
      best_entry_r <= rd_entry;
      best_slot_r  <= rd_slot;
      best_age_r   <= age;
    end
    if (ctl.eval && take_free) begin
      free_slot_r <= rd_slot;
    end
  end

  assign found      = found_r;
  assign best_entry = best_entry_r;
  assign best_slot  = best_slot_r;
  assign free_found = free_found_r;
  assign free_slot  = free_slot_r;

endmodule
